>>> rtl/core/tdr_pkg.sv
// Shared types, codes and a helper function for the divider timer.
package tdr_pkg;

	// Item operations; the fourth code is unused and does nothing.
	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2
	} op_t;

	// Register addresses.
	typedef enum logic [1:0] {
		REG_DIVIDER = 2'd0,
		REG_COUNTER = 2'd1,
		REG_MODULO  = 2'd2,
		REG_CONTROL = 2'd3
	} reg_sel_t;

	// Control register enable bit.
	localparam int unsigned ENABLE_BIT = 2;

	// Overflow sequence steps: interrupt, reload, end.
	localparam logic [2:0] SEQ_IRQ    = 3'd4;
	localparam logic [2:0] SEQ_RELOAD = 3'd5;
	localparam logic [2:0] SEQ_END    = 3'd6;

	// Divider bit watched for each rate select code.
	localparam int unsigned EDGE_BIT [4] = '{9, 3, 5, 7};

	// One input item.
	typedef struct packed {
		logic [1:0] operation;
		logic [1:0] register_select;
		logic [7:0] write_data;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_interrupt;
	} result_t;

	// Overflow sequence status, watched by the top-level checks.
	typedef struct packed {
		logic       overflow_pending;
		logic [2:0] ticks_since_overflow;
	} seq_status_t;

	// Enabled, selected divider bit under a given control value.
	function automatic logic timer_bit(logic [15:0] div, logic [7:0] ctl);
		logic sel;
		sel = div[EDGE_BIT[ctl[1:0]]];
		return ctl[ENABLE_BIT] & sel;
	endfunction

endpackage

>>> rtl/core/tdr_in_stage.sv
// Input register stage: captures one item per transfer.
module tdr_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tdr_pkg::item_t item,
	input  logic           advance,
	output logic           valid_s1,
	output tdr_pkg::item_t item_s1
);
	import tdr_pkg::*;

	logic valid_s1_q;

	// The stage takes a new item when empty or when its item moves on.
	assign in_ready = !valid_s1_q || advance;
	assign valid_s1 = valid_s1_q;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (in_ready) begin
			valid_s1_q <= in_valid;
		end
	end

	// Payload register, loaded on an input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= item;
		end
	end

endmodule

>>> rtl/core/tdr_state.sv
// Timer registers and the single-pass update for one item.
module tdr_state (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tdr_pkg::item_t       item,
	output tdr_pkg::result_t     result,
	output tdr_pkg::seq_status_t status
);
	import tdr_pkg::*;

	logic [15:0] div_q, div_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [7:0]  mod_q, mod_n;
	logic [7:0]  ctl_q, ctl_n;
	logic        pend_q, pend_n;
	logic [2:0]  ticks_q, ticks_n;
	logic        seq_run;
	logic        bump;
	logic [7:0]  rd;
	logic        irq;

	// Next state and result for the item in the input register.
	always_comb begin
		div_n   = div_q;
		cnt_n   = cnt_q;
		mod_n   = mod_q;
		ctl_n   = ctl_q;
		pend_n  = pend_q;
		ticks_n = ticks_q;
		seq_run = 1'b0;
		bump    = 1'b0;
		rd      = 8'd0;
		irq     = 1'b0;

		case (op_t'(item.operation))
			OP_TICK: begin
				div_n   = div_q + 16'd1;
				seq_run = 1'b1;
			end
			OP_READ: begin
				case (reg_sel_t'(item.register_select))
					REG_DIVIDER: rd = div_q[15:8];
					REG_COUNTER: rd = cnt_q;
					REG_MODULO:  rd = mod_q;
					default:     rd = ctl_q;
				endcase
			end
			OP_WRITE: begin
				case (reg_sel_t'(item.register_select))
					REG_DIVIDER: begin
						div_n   = 16'd0;
						seq_run = 1'b1;
					end
					REG_COUNTER: begin
						// Blocked on the interrupt step; otherwise cancels a pending reload.
						if (ticks_q != SEQ_IRQ) begin
							cnt_n   = item.write_data;
							pend_n  = 1'b0;
							ticks_n = 3'd0;
						end
					end
					REG_MODULO: begin
						mod_n = item.write_data;
						if (ticks_q == SEQ_RELOAD) begin
							cnt_n = item.write_data;
						end
					end
					default: begin
						// A control write that drops the watched bit counts as an edge.
						ctl_n = item.write_data;
						if (timer_bit(div_q, ctl_q) && !timer_bit(div_q, item.write_data)) begin
							bump = 1'b1;
						end
					end
				endcase
			end
			default: begin
			end
		endcase

		// Overflow sequence step, then the falling-edge check on the divider.
		if (seq_run) begin
			if (pend_q) begin
				ticks_n = ticks_q + 3'd1;
				if (ticks_n == SEQ_IRQ) begin
					irq = 1'b1;
				end
				if (ticks_n == SEQ_RELOAD) begin
					cnt_n = mod_q;
				end
				if (ticks_n == SEQ_END) begin
					pend_n  = 1'b0;
					ticks_n = 3'd0;
				end
			end
			if (timer_bit(div_q, ctl_q) && !timer_bit(div_n, ctl_q)) begin
				bump = 1'b1;
			end
		end

		// Counter increment; a wrap restarts the overflow sequence.
		if (bump) begin
			cnt_n = cnt_n + 8'd1;
			if (cnt_n == 8'd0) begin
				pend_n  = 1'b1;
				ticks_n = 3'd0;
			end
		end
	end

	assign result.read_data       = rd;
	assign result.timer_interrupt = irq;
	assign status.overflow_pending     = pend_q;
	assign status.ticks_since_overflow = ticks_q;

	// Timer registers, updated when the item moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q   <= 16'd0;
			cnt_q   <= 8'd0;
			mod_q   <= 8'd0;
			ctl_q   <= 8'd0;
			pend_q  <= 1'b0;
			ticks_q <= 3'd0;
		end else if (fire) begin
			div_q   <= div_n;
			cnt_q   <= cnt_n;
			mod_q   <= mod_n;
			ctl_q   <= ctl_n;
			pend_q  <= pend_n;
			ticks_q <= ticks_n;
		end
	end

endmodule

>>> rtl/core/tdr_out_stage.sv
// Output register stage: holds one result until its transfer.
module tdr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  tdr_pkg::result_t result,
	output logic             can_load,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       read_data,
	output logic             timer_interrupt
);
	import tdr_pkg::*;

	logic    out_valid_q;
	result_t result_q;

	// The register frees up when empty or when its result transfers.
	assign can_load        = !out_valid_q || out_ready;
	assign out_valid       = out_valid_q;
	assign read_data       = result_q.read_data;
	assign timer_interrupt = result_q.timer_interrupt;

	// Valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

endmodule

>>> rtl/core/divider_timer_with_reload_core.sv
// Top level of the divider timer with counter reload.
//
// Each input item is a tick, a register read or a register write, presented on
// operation, register_select and write_data under in_valid/in_ready. Every item
// gives exactly one result (read_data, timer_interrupt) under out_valid/out_ready.
// A tick advances the 16-bit divider; a falling edge of the selected divider
// bit increments the counter, and a counter wrap runs the overflow sequence
// that raises timer_interrupt and reloads the counter from the modulo register.
// An item enters an input register, is processed in one pass against the
// timer registers and lands in the output register, which offers its result
// under out_valid. One item is accepted per cycle while the receiver takes
// results, set by the single update path of the timer registers.
// Reset clears all timer registers and both stages. When the receiver stalls,
// the output register holds its result, the input register holds one more item,
// and in_ready then drops until out_ready returns.
module divider_timer_with_reload_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [1:0] register_select,
	input  logic [7:0] write_data,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	output logic       timer_interrupt
);
	import tdr_pkg::*;

	item_t       item;
	item_t       item_s1;
	logic        valid_s1;
	logic        can_load;
	logic        advance;
	result_t     result;
	seq_status_t status;

	assign item.operation       = operation;
	assign item.register_select = register_select;
	assign item.write_data      = write_data;

	// The item in the input register is processed when the output register frees.
	assign advance = valid_s1 && can_load;

	tdr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tdr_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result),
		.status (status)
	);

	tdr_out_stage u_out (
		.clk             (clk),
		.arst_n          (arst_n),
		.load            (advance),
		.result          (result),
		.can_load        (can_load),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.read_data       (read_data),
		.timer_interrupt (timer_interrupt)
	);

	// The overflow sequence never runs past its end step.
	a_ticks_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.ticks_since_overflow <= SEQ_END)
		else $error("overflow step count out of range");

	// The step count is zero whenever no overflow is pending.
	a_ticks_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!status.overflow_pending |-> status.ticks_since_overflow == 3'd0)
		else $error("step count nonzero without pending overflow");

	// The input side only stalls when both stages are full and the output is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid && !out_ready))
		else $error("input stalled without a full pipeline");

	// A result with the interrupt set comes only from a pending sequence.
	a_irq_source: assert property (@(posedge clk) disable iff (!arst_n)
		advance && result.timer_interrupt |-> status.overflow_pending)
		else $error("interrupt raised without pending overflow");

endmodule
